### rtl/core/f4ma_pkg.sv
// Shared constants, types and helper functions for the four-lane fp32 multiply-add unit.
package f4ma_pkg;

	localparam int LANES_DEF = 4;
	localparam int MAX_LANES = 4;
	localparam logic [31:0] CANON_NAN = 32'h7FC00000;

	typedef enum logic [1:0] {
		OP_SMUL = 2'd0,
		OP_VMUL = 2'd1,
		OP_VMADD = 2'd2,
		OP_VMSUB = 2'd3
	} op_t;

	// Lane control that travels with the pipeline.
	typedef struct packed {
		logic act;
		logic addop;
		logic neg;
	} lane_ctl_t;

	// Round a magnitude with a guard/sticky tail to nearest even.
	// sig holds the kept 24 bits plus 2 extra (guard, round) bits; sticky separate.
	function automatic logic [31:0] pack_rne(input logic sgn, input logic signed [10:0] exp,
		input logic [25:0] sig, input logic sticky);
		logic [23:0] m;
		logic g, r, s, up;
		logic [24:0] mr;
		logic signed [10:0] e;
		logic [31:0] o;
		begin
			m = sig[25:2];
			g = sig[1];
			r = sig[0];
			s = sticky;
			up = g & (r | s | m[0]);
			mr = {1'b0, m} + {24'd0, up};
			e = exp;
			if (mr[24]) begin
				mr = mr >> 1;
				e = e + 11'sd1;
			end
			if (e >= 11'sd255)
				o = {sgn, 8'hFF, 23'd0};
			else if (mr[23] == 1'b0)
				o = {sgn, 8'd0, mr[22:0]};
			else
				o = {sgn, e[7:0], mr[22:0]};
			pack_rne = o;
		end
	endfunction

endpackage

### rtl/core/f4ma_lane.sv
// One fp32 lane: multiply, round, then add/subtract, round, in five register stages.
module f4ma_lane (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vld,
	input  f4ma_pkg::lane_ctl_t  ctl,
	input  logic [31:0]          a,
	input  logic [31:0]          b,
	input  logic [31:0]          c,
	output logic [31:0]          res
);

	// ---------------- stage 1: unpack and multiply ----------------
	logic [23:0] ma, mb;
	logic signed [10:0] ea, eb;
	logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	always_comb begin
		ma = {(a[30:23] != 8'd0), a[22:0]};
		mb = {(b[30:23] != 8'd0), b[22:0]};
		ea = (a[30:23] == 8'd0) ? 11'sd1 : $signed({3'd0, a[30:23]});
		eb = (b[30:23] == 8'd0) ? 11'sd1 : $signed({3'd0, b[30:23]});
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
	end

	logic [47:0] prod_s1;
	logic signed [10:0] pe_s1;
	logic ps_s1, pnan_s1, pinf_s1, pzero_s1;
	f4ma_pkg::lane_ctl_t ctl_s1;
	logic [31:0] c_s1;
	logic v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= vld;
		end
	end
	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		pe_s1 <= ea + eb - 11'sd127;
		ps_s1 <= a[31] ^ b[31];
		pnan_s1 <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
		pinf_s1 <= a_inf | b_inf;
		pzero_s1 <= a_zero | b_zero;
		ctl_s1 <= ctl;
		c_s1 <= c;
	end

	// ---------------- stage 2: normalize and round product ----------------
	logic [5:0] lz;
	logic [47:0] pn;
	logic signed [10:0] pen;
	logic [6:0] rsh;
	logic [49:0] pw;
	logic [49:0] pr;
	logic psticky;
	logic [31:0] pbits;
	always_comb begin
		lz = 6'd0;
		for (int i = 0; i < 48; i++)
			if (prod_s1[i]) lz = 6'(47 - i);
		pn = prod_s1 << lz;
		// pn[47] is the leading one; value = pn * 2^(pen-127-47) with pen exp of bit47
		pen = pe_s1 + 11'sd1 - $signed({5'd0, lz});
		rsh = 7'd0;
		if (pen < 11'sd1)
			rsh = (pen < -11'sd48) ? 7'd50 : 7'(11'sd1 - pen);
		pw = {pn, 2'b00} >> rsh;
		pr = pw;
		psticky = 1'b0;
		for (int i = 0; i < 50; i++)
			if (7'(i) < rsh && i < 50) psticky = psticky | (({pn, 2'b00} >> i) & 50'd1) != 50'd0;
		if (rsh != 7'd0) pen = 11'sd1;
		psticky = psticky | (pr[23:0] != 24'd0);
		pbits = f4ma_pkg::pack_rne(ps_s1, pen, pr[49:24], psticky);
		if (pnan_s1) pbits = f4ma_pkg::CANON_NAN;
		else if (pinf_s1) pbits = {ps_s1, 8'hFF, 23'd0};
		else if (pzero_s1) pbits = {ps_s1, 31'd0};
	end

	logic [31:0] p_s2, c_s2;
	f4ma_pkg::lane_ctl_t ctl_s2;
	logic v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		p_s2 <= pbits;
		c_s2 <= c_s1;
		ctl_s2 <= ctl_s1;
	end

	// ---------------- stage 3: align for add ----------------
	logic [31:0] y;
	logic x_nan, y_nan, x_inf, y_inf;
	logic [7:0] ex, ey;
	logic [23:0] mx, my;
	logic swap;
	logic [7:0] d;
	logic [27:0] big, sm_al;
	logic [27:0] sm_full;
	logic ssticky;
	logic sb, ss;
	logic [7:0] ebig;
	always_comb begin
		y = {p_s2[31] ^ ctl_s2.neg, p_s2[30:0]};
		x_nan = (c_s2[30:23] == 8'hFF) && (c_s2[22:0] != 23'd0);
		y_nan = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
		x_inf = (c_s2[30:23] == 8'hFF) && !x_nan;
		y_inf = (y[30:23] == 8'hFF) && !y_nan;
		ex = (c_s2[30:23] == 8'd0) ? 8'd1 : c_s2[30:23];
		ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		mx = {(c_s2[30:23] != 8'd0), c_s2[22:0]};
		my = {(y[30:23] != 8'd0), y[22:0]};
		swap = {ey, my} > {ex, mx};
		big = swap ? {1'b0, my, 3'b000} : {1'b0, mx, 3'b000};
		sm_full = swap ? {1'b0, mx, 3'b000} : {1'b0, my, 3'b000};
		d = swap ? ey - ex : ex - ey;
		ebig = swap ? ey : ex;
		sb = swap ? y[31] : c_s2[31];
		ss = swap ? c_s2[31] : y[31];
		if (d > 8'd27) begin
			sm_al = 28'd0;
			ssticky = sm_full != 28'd0;
		end else begin
			sm_al = sm_full >> d;
			ssticky = (sm_full & ~(28'hFFFFFFF << d)) != 28'd0;
		end
	end

	logic [27:0] big_s3, sm_s3;
	logic stk_s3, sub_s3, sgn_s3, xs_s3, ys_s3;
	logic [7:0] eb_s3;
	logic [31:0] p_s3;
	logic spec_s3;
	logic [31:0] specv_s3;
	f4ma_pkg::lane_ctl_t ctl_s3;
	logic v_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		big_s3 <= big;
		sm_s3 <= sm_al | {27'd0, ssticky};
		stk_s3 <= ssticky;
		sub_s3 <= sb ^ ss;
		sgn_s3 <= sb;
		xs_s3 <= c_s2[31];
		ys_s3 <= y[31];
		eb_s3 <= ebig;
		p_s3 <= p_s2;
		ctl_s3 <= ctl_s2;
		spec_s3 <= x_nan | y_nan | x_inf | y_inf;
		if (x_nan | y_nan | (x_inf & y_inf & (c_s2[31] != y[31])))
			specv_s3 <= f4ma_pkg::CANON_NAN;
		else if (x_inf)
			specv_s3 <= c_s2;
		else
			specv_s3 <= y;
	end

	// ---------------- stage 4: add ----------------
	logic [28:0] sum;
	always_comb begin
		if (sub_s3)
			sum = {1'b0, big_s3} - {1'b0, sm_s3};
		else
			sum = {1'b0, big_s3} + {1'b0, sm_s3};
	end
	logic [28:0] sum_s4;
	logic sgn_s4, bothneg_s4, spec_s4, stk_s4;
	logic [7:0] eb_s4;
	logic [31:0] p_s4, specv_s4;
	f4ma_pkg::lane_ctl_t ctl_s4;
	logic v_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		sum_s4 <= sum;
		sgn_s4 <= sgn_s3;
		bothneg_s4 <= xs_s3 & ys_s3;
		spec_s4 <= spec_s3;
		stk_s4 <= stk_s3;
		eb_s4 <= eb_s3;
		p_s4 <= p_s3;
		specv_s4 <= specv_s3;
		ctl_s4 <= ctl_s3;
	end

	// ---------------- stage 5: normalize, round, select ----------------
	// sum bit 26 is the unit position at exponent eb (bits 25:3 fraction, 2:0 g/r/s).
	logic [4:0] slz;
	logic [28:0] sn;
	logic signed [10:0] se;
	logic [31:0] abits, rbits;
	always_comb begin
		slz = 5'd0;
		for (int i = 0; i < 29; i++)
			if (sum_s4[i]) slz = 5'(28 - i);
		se = $signed({3'd0, eb_s4}) + 11'sd2 - $signed({6'd0, slz});
		// limit left shift so exponent stays >= 1 (subnormal result)
		if (se < 11'sd1) begin
			sn = sum_s4 << (5'(slz) - 5'(11'sd1 - se));
			se = 11'sd1;
		end else begin
			sn = sum_s4 << slz;
		end
		if (sum_s4 == 29'd0)
			abits = {bothneg_s4, 31'd0};
		else
			abits = f4ma_pkg::pack_rne(sgn_s4, se, sn[28:3], (sn[2:0] != 3'd0) | stk_s4);
		if (spec_s4) abits = specv_s4;
		if (!ctl_s4.act)
			rbits = 32'd0;
		else if (!ctl_s4.addop)
			rbits = p_s4;
		else
			rbits = abits;
		if (rbits[30:23] == 8'hFF && rbits[22:0] != 23'd0) rbits = f4ma_pkg::CANON_NAN;
	end

	always_ff @(posedge clk) begin
		if (v_s4) res <= rbits;
	end

endmodule

### rtl/core/fp32_four_lane_multiply_add_top.sv
// Top level of the four-lane fp32 multiply / multiply-add unit.
//
//  channel | handshake       | payload
//  --------+-----------------+---------------------------------------------
//  input   | start, busy     | opcode, a/b/acc_pair_low, a/b/acc_pair_high
//  result  | done (strobe)   | res_pair_low, res_pair_high
//
// Each item's result is strobed on done once it has passed through the lane pipeline.
// A new item may transfer in every cycle, busy is always low.
// Depth is set by the lane pipeline: multiply, product round, align, add,
// normalize/round into the output register.
// Reset clears the valid bits only; the receiver cannot stall, so nothing holds.
module fp32_four_lane_multiply_add_top #(
	parameter int LANES = f4ma_pkg::LANES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [63:0] a_pair_low,
	input  logic [63:0] a_pair_high,
	input  logic [63:0] b_pair_low,
	input  logic [63:0] b_pair_high,
	input  logic [63:0] acc_pair_low,
	input  logic [63:0] acc_pair_high,
	output logic        done,
	output logic [63:0] res_pair_low,
	output logic [63:0] res_pair_high
);

	localparam int DEPTH = 5;

	logic [127:0] a_all, b_all, c_all;
	logic [127:0] r_all;
	logic [DEPTH-1:0] vld_q;
	logic xfer;

	// Never hold off input: the pipeline advances every cycle.
	assign busy = 1'b0;
	assign xfer = start & ~busy;

	assign a_all = {a_pair_high, a_pair_low};
	assign b_all = {b_pair_high, b_pair_low};
	assign c_all = {acc_pair_high, acc_pair_low};

	for (genvar i = 0; i < f4ma_pkg::MAX_LANES; i++) begin : g_lane
		if (i < LANES) begin : g_on
			f4ma_pkg::lane_ctl_t ctl;
			always_comb begin
				ctl.act = (f4ma_pkg::op_t'(opcode) != f4ma_pkg::OP_SMUL) || (i == 0);
				ctl.addop = (f4ma_pkg::op_t'(opcode) == f4ma_pkg::OP_VMADD) ||
					(f4ma_pkg::op_t'(opcode) == f4ma_pkg::OP_VMSUB);
				ctl.neg = (f4ma_pkg::op_t'(opcode) == f4ma_pkg::OP_VMSUB);
			end
			f4ma_lane u_lane (
				.clk(clk), .arst_n(arst_n), .vld(xfer), .ctl(ctl),
				.a(a_all[i*32 +: 32]), .b(b_all[i*32 +: 32]), .c(c_all[i*32 +: 32]),
				.res(r_all[i*32 +: 32])
			);
		end else begin : g_off
			// Drop lanes beyond LANES: they read as zero.
			assign r_all[i*32 +: 32] = 32'd0;
		end
	end

	// Valid bits travel alongside the lane stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[DEPTH-2:0], xfer};
		end
	end

	assign done = vld_q[DEPTH-1];
	assign res_pair_low = r_all[63:0];
	assign res_pair_high = r_all[127:64];

endmodule

### rtl/core/f4ma_checker.sv
// Port-level checker for the four-lane fp32 multiply-add unit, bound to the top level.
module f4ma_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  opcode,
	input logic        done,
	input logic [63:0] res_pair_low,
	input logic [63:0] res_pair_high
);

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done) else $error("missing result strobe");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 5)) else $error("result without transfer");

	a_scalar_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode == f4ma_pkg::OP_SMUL) |-> ##5
		(res_pair_high == 64'd0 && res_pair_low[63:32] == 32'd0))
		else $error("inactive lanes not zero");

	a_full_rate: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("unit stalled input");

endmodule

bind fp32_four_lane_multiply_add_top f4ma_checker u_f4ma_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
	.done(done), .res_pair_low(res_pair_low), .res_pair_high(res_pair_high)
);

### dv/tb_top.sv
// Testbench for the four-lane fp32 multiply / multiply-add unit with a bit-exact predictor.
module tb_top;
	import f4ma_pkg::*;

	// Predicts each lane in integer arithmetic (sign, significand, exponent), rounds to
	// nearest even with full subnormal support, and keeps the expected result vectors in
	// transfer order so the strobed results can be compared as they come out.
	class fma_scoreboard;
		logic [127:0] pending_res[$];
		int unsigned errors;

		static function logic is_nan(logic [31:0] v);
			return v[30:23] == 8'hFF && v[22:0] != 0;
		endfunction

		static function logic is_inf(logic [31:0] v);
			return v[30:23] == 8'hFF && v[22:0] == 0;
		endfunction

		static function logic is_zero(logic [31:0] v);
			return v[30:0] == 0;
		endfunction

		// Value is m * 2^e.
		static function void unpack_lane(logic [31:0] v, output logic [63:0] m, output int e);
			if (v[30:23] == 0) begin
				m = {41'd0, v[22:0]};
				e = -149;
			end else begin
				m = {40'd0, 1'b1, v[22:0]};
				e = int'(v[30:23]) - 150;
			end
		endfunction

		// Round sign * m * 2^e to fp32.
		static function logic [31:0] round_to_fp32(logic sgn, logic [63:0] m, int e);
			int msb, ex, sh;
			logic [127:0] x;
			logic [24:0] q;
			logic g, st;
			if (m == 0)
				return {sgn, 31'd0};
			msb = 63;
			while (!m[msb])
				msb--;
			ex = msb + e;
			if (ex < -126)
				ex = -126;
			sh = (ex - 23) - e;
			if (sh > 0) begin
				if (sh > 127)
					sh = 127;
				x = {m, 64'd0} >> sh;
				q = x[88:64];
				g = x[63];
				st = |x[62:0];
				if (g && (st || q[0]))
					q = q + 25'd1;
			end else begin
				q = 25'(m << (-sh));
			end
			if (q[24]) begin
				q = q >> 1;
				ex++;
			end
			if (ex > 127)
				return {sgn, 8'hFF, 23'd0};
			if (!q[23])
				return {sgn, 8'd0, q[22:0]};
			return {sgn, 8'(ex + 127), q[22:0]};
		endfunction

		static function logic [31:0] mul_lane(logic [31:0] a, logic [31:0] b);
			logic [63:0] ma, mb;
			int ea, eb;
			logic s;
			s = a[31] ^ b[31];
			if (is_nan(a) || is_nan(b))
				return CANON_NAN;
			if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b)))
				return CANON_NAN;
			if (is_inf(a) || is_inf(b))
				return {s, 8'hFF, 23'd0};
			unpack_lane(a, ma, ea);
			unpack_lane(b, mb, eb);
			return round_to_fp32(s, ma * mb, ea + eb);
		endfunction

		// c + p, with p already carrying its effective sign.
		static function logic [31:0] add_lane(logic [31:0] c, logic [31:0] p);
			logic [63:0] mx, my, mt, lost, m;
			int ex, ey, et, d;
			logic sx, sy, st, s;
			if (is_nan(c) || is_nan(p))
				return CANON_NAN;
			if (is_inf(c) && is_inf(p))
				return (c[31] == p[31]) ? c : CANON_NAN;
			if (is_inf(c))
				return c;
			if (is_inf(p))
				return p;
			unpack_lane(c, mx, ex);
			unpack_lane(p, my, ey);
			sx = c[31];
			sy = p[31];
			// Leave headroom under the significands for guard and sticky bits.
			mx = mx << 30;
			my = my << 30;
			ex -= 30;
			ey -= 30;
			if (ex < ey) begin
				mt = mx; mx = my; my = mt;
				et = ex; ex = ey; ey = et;
				st = sx; sx = sy; sy = st;
			end
			d = ex - ey;
			if (d > 40) begin
				my = (my != 0) ? 64'd1 : 64'd0;
			end else begin
				lost = my & ((64'd1 << d) - 64'd1);
				my = (my >> d) | {63'd0, lost != 0};
			end
			if (sx == sy) begin
				m = mx + my;
				s = sx;
			end else if (mx >= my) begin
				m = mx - my;
				s = sx;
			end else begin
				m = my - mx;
				s = sy;
			end
			// An exact zero sum is +0 unless both addends were -0.
			if (m == 0)
				s = sx & sy;
			return round_to_fp32(s, m, ex);
		endfunction

		static function logic [31:0] predict_lane(op_t op, logic [31:0] a, logic [31:0] b,
			logic [31:0] c);
			logic [31:0] prod;
			prod = mul_lane(a, b);
			case (op)
				OP_VMADD: return add_lane(c, prod);
				OP_VMSUB: return add_lane(c, prod ^ 32'h8000_0000);
				default:  return prod;
			endcase
		endfunction

		function void note_transfer(op_t op, logic [127:0] a, logic [127:0] b,
			logic [127:0] c);
			logic [127:0] r;
			r = '0;
			for (int i = 0; i < MAX_LANES; i++)
				if (op != OP_SMUL || i == 0)
					r[32*i +: 32] = predict_lane(op, a[32*i +: 32], b[32*i +: 32],
						c[32*i +: 32]);
			pending_res.push_back(r);
		endfunction

		function void check_result(logic [63:0] lo, logic [63:0] hi);
			logic [127:0] r;
			if (pending_res.size() == 0) begin
				$display("%0t: unexpected result %h_%h", $time, hi, lo);
				errors++;
				return;
			end
			r = pending_res.pop_front();
			if (lo !== r[63:0]) begin
				$display("%0t: res_pair_low expected %h actual %h", $time, r[63:0], lo);
				errors++;
			end
			if (hi !== r[127:64]) begin
				$display("%0t: res_pair_high expected %h actual %h", $time, r[127:64], hi);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  opcode;
	logic [63:0] a_pair_low, a_pair_high;
	logic [63:0] b_pair_low, b_pair_high;
	logic [63:0] acc_pair_low, acc_pair_high;
	logic        done;
	logic [63:0] res_pair_low, res_pair_high;

	fma_scoreboard sb;
	int unsigned   quiet_cycles;

	fp32_four_lane_multiply_add_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.a_pair_low    (a_pair_low),
		.a_pair_high   (a_pair_high),
		.b_pair_low    (b_pair_low),
		.b_pair_high   (b_pair_high),
		.acc_pair_low  (acc_pair_low),
		.acc_pair_high (acc_pair_high),
		.done          (done),
		.res_pair_low  (res_pair_low),
		.res_pair_high (res_pair_high)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Note each input transfer and check each strobed result. Outputs are registered,
	// so at the rising edge we still see the values of the cycle that is ending.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_transfer(op_t'(opcode), {a_pair_high, a_pair_low},
					{b_pair_high, b_pair_low}, {acc_pair_high, acc_pair_low});
			if (done)
				sb.check_result(res_pair_low, res_pair_high);
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 2000) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Present one item at the falling edge and hold it until the transfer.
	task automatic send_item(op_t op, logic [127:0] a, logic [127:0] b, logic [127:0] c);
		@(negedge clk);
		start = 1'b1;
		opcode = op;
		{a_pair_high, a_pair_low} = a;
		{b_pair_high, b_pair_low} = b;
		{acc_pair_high, acc_pair_low} = c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Drop start for a number of cycles.
	task automatic idle_cycles(int n);
		if (n > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (n - 1)
				@(negedge clk);
		end
	endtask

	// Draw an operand from a mix of classes so specials and edge exponents show up often.
	function automatic logic [31:0] rand_operand();
		logic s;
		logic [22:0] f;
		s = 1'($urandom_range(0, 1));
		f = 23'($urandom);
		case ($urandom_range(0, 11))
			0, 1: return $urandom;
			2:    return {s, 31'd0};
			3:    return {s, 8'hFF, 23'd0};
			4:    return {s, 8'hFF, (f == 0) ? 23'd1 : f};
			5:    return {s, 8'd0, f};
			6:    return {s, 8'($urandom_range(200, 254)), f};
			7:    return {s, 8'($urandom_range(1, 40)), f};
			8:    return {s, 8'd127, 23'd0};
			default: return {s, 8'($urandom_range(100, 154)), f};
		endcase
	endfunction

	// Random item; for multiply-add, often aim the accumulator near the product so the
	// sum cancels deeply.
	task automatic send_random();
		logic [127:0] a, b, c;
		logic [31:0] p;
		op_t op;
		op = op_t'($urandom_range(0, 3));
		for (int i = 0; i < 4; i++) begin
			a[32*i +: 32] = rand_operand();
			b[32*i +: 32] = rand_operand();
			c[32*i +: 32] = rand_operand();
			if ($urandom_range(0, 2) == 0) begin
				p = fma_scoreboard::mul_lane(a[32*i +: 32], b[32*i +: 32]);
				c[32*i +: 32] = p ^ 32'($urandom_range(0, 7)) ^
					{1'($urandom_range(0, 1)), 31'd0};
			end
		end
		send_item(op, a, b, c);
	endtask

	initial begin
		int sent;
		int burst;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_SMUL;
		a_pair_low = '0; a_pair_high = '0;
		b_pair_low = '0; b_pair_high = '0;
		acc_pair_low = '0; acc_pair_high = '0;
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, each opcode, specials, inactive lanes, ignored accumulator.
		send_item(OP_SMUL, {4{32'h3FC0_0000}}, {4{32'h4000_0000}}, {4{32'h4040_0000}});
		send_item(OP_VMUL, {4{32'h3FC0_0000}}, {4{32'h4000_0000}}, {4{32'hFFFF_FFFF}});
		send_item(OP_VMADD, {4{32'h3F80_0000}}, {4{32'h4000_0000}}, {4{32'h4040_0000}});
		send_item(OP_VMSUB, {4{32'h3F80_0000}}, {4{32'h4000_0000}}, {4{32'h4040_0000}});
		send_item(OP_VMUL, '1, '1, '1);
		send_item(OP_VMADD, '0, '0, '0);
		send_item(OP_VMSUB, '1, '1, '1);
		// Inf times zero, inf times finite, NaN operands.
		send_item(OP_VMUL, {32'h7F80_0000, 32'hFF80_0000, 32'h7FC1_2345, 32'h7F80_0000},
			{32'h0000_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h8000_0001}, '0);
		// Inf minus inf in the accumulation.
		send_item(OP_VMADD, {4{32'h7F80_0000}}, {4{32'h3F80_0000}}, {4{32'hFF80_0000}});
		send_item(OP_VMSUB, {4{32'h7F80_0000}}, {4{32'h3F80_0000}}, {4{32'h7F80_0000}});
		// Overflow and underflow, subnormal products.
		send_item(OP_VMUL, {32'h7F7F_FFFF, 32'h0080_0000, 32'h0000_0001, 32'h3F00_0000},
			{32'h7F7F_FFFF, 32'h3F00_0000, 32'h3F00_0000, 32'h0000_0003}, '0);
		// Exact cancellation and signed zeros.
		send_item(OP_VMSUB, {32'h3F80_0000, 32'h8000_0000, 32'h0000_0000, 32'h4000_0000},
			{32'h3F80_0000, 32'h0000_0000, 32'h0000_0000, 32'h4000_0000},
			{32'h3F80_0000, 32'h8000_0000, 32'h8000_0000, 32'h4080_0000});
		send_item(OP_VMADD, {32'h3F80_0001, 32'h0000_0001, 32'h7F7F_FFFF, 32'h3380_0000},
			{32'h3F80_0001, 32'h0000_0001, 32'h4000_0000, 32'h3F80_0000},
			{32'hBF80_0002, 32'h0000_0001, 32'hFF7F_FFFF, 32'h3F80_0000});
		send_item(OP_SMUL, {32'h0, 32'h0, 32'h0, 32'h7F80_0000},
			{32'h0, 32'h0, 32'h0, 32'h0}, '1);

		// Random bursts with random gaps, some stretches back to back.
		sent = 0;
		while (sent < 1550) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst; k++) begin
				send_random();
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				idle_cycles($urandom_range(1, 8));
		end
		idle_cycles(1);

		// Drain: wait for every expected result, then allow for the pipeline depth.
		while (sb.pending_res.size() != 0)
			@(posedge clk);
		repeat (12)
			@(posedge clk);
		if (sb.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
